[design/skbs_pkg.sv]
// ----------------------------------------------------------------------------
// skbs_pkg
// Shared types and constants for the sorted key binary search block.
// ----------------------------------------------------------------------------
package skbs_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  // interval bounds run from 0 up to the depth itself
  localparam int unsigned IDX_W       = ADDR_W + 1;

  // fixed field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned COUNT_W = 11;

  // stream packing
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // opcodes carried on the input tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic wr;        // store the incoming key
    logic start;     // load a search and issue the first probe, if any
    logic step;      // narrow the interval and issue the next probe
    logic load_out;  // capture the result into the output register
  } skbs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic probe;       // a probe is outstanding for the current interval
    logic hit;         // probed key equals the search key
    logic next_empty;  // interval is empty after this probe
  } skbs_status_t;

endpackage

[design/skbs_ram.sv]
// ----------------------------------------------------------------------------
// skbs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module skbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/skbs_ctrl.sv]
// ----------------------------------------------------------------------------
// skbs_ctrl
// Controller for the binary search: input handshake, probe sequencing and
// the output valid register.
// ----------------------------------------------------------------------------
module skbs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_opcode_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output skbs_pkg::skbs_cmd_t   cmd_o,
  input  skbs_pkg::skbs_status_t status_i
);
  import skbs_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic finish;
  logic out_free;

  // search ends on a hit, on an empty interval, or with no probe at all
  assign finish   = !status_i.probe || status_i.hit || status_i.next_empty;
  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SEARCH;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (finish) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/skbs_dp.sv]
// ----------------------------------------------------------------------------
// skbs_dp
// Datapath for the binary search: key table, interval bounds, probe compare,
// entry count register and result register.
// ----------------------------------------------------------------------------
module skbs_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [skbs_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic [skbs_pkg::POS_W-1:0]    in_position_i,
  input  logic [skbs_pkg::KEY_W-1:0]    in_key_i,
  input  skbs_pkg::skbs_cmd_t           cmd_i,
  output skbs_pkg::skbs_status_t        status_o,
  output logic                          found_o,
  output logic [skbs_pkg::POS_W-1:0]    match_position_o
);
  import skbs_pkg::*;

  // midpoint of the closed interval [lo, hi_p1 - 1], valid when lo < hi_p1
  function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                               input logic [IDX_W-1:0] hi_p1);
    logic [IDX_W-1:0] span;
    span   = hi_p1 - lo - IDX_W'(1);
    mid_of = lo + (span >> 1);
  endfunction

  logic [COUNT_W-1:0] entry_count_q;
  logic [IDX_W-1:0]   count_eff;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   lo_q, lo_d;
  logic [IDX_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]   mid_q, mid_d;
  logic [IDX_W-1:0]   mid_start;
  logic [KEY_W-1:0]   rdata;
  logic               key_below;
  logic               wr_en;
  logic               rd_en;
  logic               found_q;
  logic [POS_W-1:0]   pos_q;
  logic               hit_now;

  // entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // counts beyond the table are clamped to its depth
  assign count_eff = (32'(entry_count_q) > TABLE_DEPTH) ? IDX_W'(TABLE_DEPTH)
                                                        : IDX_W'(entry_count_q);
  assign mid_start = mid_of('0, count_eff);

  // probe compare against the registered read data
  assign key_below = $signed(rdata) < $signed(key_q);

  assign status_o.probe = lo_q < hi_q;
  assign status_o.hit   = rdata == key_q;
  assign hit_now        = status_o.probe && status_o.hit;

  // interval update for a miss on this probe
  always_comb begin
    if (key_below) begin
      lo_d = mid_q + IDX_W'(1);
      hi_d = hi_q;
    end else begin
      lo_d = lo_q;
      hi_d = mid_q;
    end
    mid_d = mid_of(lo_d, hi_d);
  end

  assign status_o.next_empty = !(lo_d < hi_d);

  // search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= in_key_i;
      lo_q  <= '0;
      hi_q  <= count_eff;
      mid_q <= mid_start;
    end else if (cmd_i.step) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      mid_q <= mid_d;
    end
  end

  // key table
  assign wr_en = cmd_i.wr && (32'(in_position_i) < TABLE_DEPTH);
  assign rd_en = (cmd_i.start && (count_eff != '0)) || cmd_i.step;

  skbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(in_position_i)),
    .wdata_i (in_key_i),
    .re_i    (rd_en),
    .raddr_i (cmd_i.start ? ADDR_W'(mid_start) : ADDR_W'(mid_d)),
    .rdata_o (rdata)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_q <= hit_now;
      pos_q   <= hit_now ? POS_W'(mid_q) : '0;
    end
  end

  assign found_o          = found_q;
  assign match_position_o = pos_q;

endmodule

[design/sorted_key_binary_search.sv]
// ----------------------------------------------------------------------------
// sorted_key_binary_search
// Table of signed 32-bit keys with binary search lookup.
// ----------------------------------------------------------------------------
// A write transaction (tuser 0) stores a key at a table position and gives
// no result; the block takes the next transaction in the following cycle. A
// search transaction (tuser 1) runs a binary search over the first
// entry_count positions (clamped to the table depth) and returns one result:
// found on m_axis_tuser and, on a hit, the position in m_axis_tdata, else 0.
// A search holds the input side until it finishes and makes at most
// ceil(log2(entry_count + 1)) probes, so 11 for a full table of 1024; with
// entry_count 0 no probe is made. A search that finishes while an earlier
// result still waits on the result side holds in its last cycle until that
// result is taken. Each probe goes through the compare and next-address loop
// around the table RAM's registered read port. The result register lets a
// finished result wait while the next transaction is accepted. Keys must be
// written before they are searched and software keeps the table sorted
// ascending.
// ----------------------------------------------------------------------------
module sorted_key_binary_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: entry_count
  input  logic                              cfg_we_i,
  input  logic [skbs_pkg::COUNT_W-1:0]      cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [skbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // entry_position[9:0], key[41:10]
  input  logic                              s_axis_tuser,  // opcode[0]
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [skbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // match_position[9:0]
  output logic                              m_axis_tuser   // found[0]
);
  import skbs_pkg::*;

  skbs_cmd_t        cmd;
  skbs_status_t     status;
  logic             found;
  logic [POS_W-1:0] match_position;

  // controller
  skbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath
  skbs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_position_i    (s_axis_tdata[POS_W-1:0]),
    .in_key_i         (s_axis_tdata[POS_W+KEY_W-1:POS_W]),
    .cmd_i            (cmd),
    .status_o         (status),
    .found_o          (found),
    .match_position_o (match_position)
  );

  // result packing
  assign m_axis_tuser = found;
  assign m_axis_tdata = {(OUT_DATA_W - POS_W)'(0), match_position};

endmodule

[design/skbs_checker.sv]
// ----------------------------------------------------------------------------
// skbs_checker
// Port level checks for the sorted key binary search block.
// ----------------------------------------------------------------------------
module skbs_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [skbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tuser
);
  import skbs_pkg::*;

  // an accepted search takes the input side out of ready
  a_search_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SEARCH) |=> !s_axis_tready)
    else $error("input accepted right after a search transaction");

  // a write leaves the input side ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE) |=> s_axis_tready)
    else $error("input stalled after a write transaction");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss with nonzero position");

  // stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

endmodule

bind sorted_key_binary_search skbs_checker u_skbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[dv/tb_sorted_key_binary_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_binary_search
// Self-checking bench for the sorted key binary search table.
// ----------------------------------------------------------------------------
// A queue of pending transactions feeds a clocked stream driver. Every accepted
// transaction is applied to a local copy of the key table, and every search
// pushes its predicted answer. A clocked monitor compares each result with the
// oldest predicted answer. The stimulus generator keeps its own shadow of the
// table and writes any position that a search would probe before that search
// is queued, so no unwritten entry is ever read. Runs go through several
// entry_count settings, from an empty table up past the table depth.
// ----------------------------------------------------------------------------
module tb_sorted_key_binary_search;
  import skbs_pkg::*;

  localparam int RAND_ITEMS     = 600;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RESET_CYCLES   = 9;

  // one input transaction
  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
  } query_t;

  // one lookup answer
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } lookup_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // entry_position[9:0], key[41:10]
  logic                  s_axis_tuser  = OP_WRITE;  // opcode[0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // match_position[9:0]
  logic                  m_axis_tuser;  // found[0]

  sorted_key_binary_search u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // shared state
  query_t             query_q[$];
  lookup_t            answer_q[$];
  query_t             in_flight;
  lookup_t            due;
  logic [COUNT_W-1:0] count_reg = '0;
  logic [KEY_W-1:0]   key_mem[TABLE_DEPTH];
  logic [KEY_W-1:0]   shadow_keys[TABLE_DEPTH];
  bit                 shadow_set[TABLE_DEPTH];
  bit                 steady = 1'b0;
  int                 send_gap;
  int                 recv_gap;
  int                 fail_cnt = 0;
  int                 quiet_cycles = 0;
  int                 queued_items = 0;

  // used part of the table, clamped to the depth
  function automatic int eff_count();
    return (count_reg > TABLE_DEPTH) ? int'(TABLE_DEPTH) : int'(count_reg);
  endfunction

  // mostly short gaps, a few long ones, none in steady stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // binary search over the predicted table
  function automatic lookup_t binary_lookup(logic signed [KEY_W-1:0] k);
    lookup_t res;
    int      lo;
    int      hi;
    int      mid;
    res = '0;
    lo  = 0;
    hi  = eff_count() - 1;
    while (lo <= hi && !res.found) begin
      mid = lo + (hi - lo) / 2;
      if ($signed(key_mem[mid]) == k) begin
        res.found = 1'b1;
        res.pos   = mid[POS_W-1:0];
      end else if ($signed(key_mem[mid]) < k) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  task automatic log_fail(string msg);
    if (fail_cnt < 10) $display("%s", msg);
    fail_cnt++;
  endtask

  // stimulus helpers: queue a write and track it in the shadow table
  task automatic add_write(logic [POS_W-1:0] pos, logic [KEY_W-1:0] k);
    query_t q;
    q.op  = OP_WRITE;
    q.pos = pos;
    q.key = k;
    shadow_keys[pos] = k;
    shadow_set[pos]  = 1'b1;
    query_q.push_back(q);
    queued_items++;
  endtask

  // key that fits between the nearest written neighbors of a position
  function automatic logic [KEY_W-1:0] fill_value(int p);
    longint          lo_k;
    longint          hi_k;
    longint          tmp;
    longint unsigned rnd;
    bit              got;
    int              i;
    lo_k = -64'sd2147483648;
    hi_k = 64'sd2147483647;
    got  = 1'b0;
    for (i = p - 1; i >= 0 && !got; i--) begin
      if (shadow_set[i]) begin
        lo_k = longint'($signed(shadow_keys[i]));
        got  = 1'b1;
      end
    end
    got = 1'b0;
    for (i = p + 1; i < int'(TABLE_DEPTH) && !got; i++) begin
      if (shadow_set[i]) begin
        hi_k = longint'($signed(shadow_keys[i]));
        got  = 1'b1;
      end
    end
    if (lo_k > hi_k) begin
      tmp  = lo_k;
      lo_k = hi_k;
      hi_k = tmp;
    end
    rnd = {$urandom, $urandom};
    tmp = lo_k + longint'(rnd % longint'(hi_k - lo_k + 1));
    return tmp[KEY_W-1:0];
  endfunction

  // queue a search, first writing every unwritten position on its probe path
  task automatic add_search(logic signed [KEY_W-1:0] k);
    query_t q;
    int     lo;
    int     hi;
    int     mid;
    bit     hit;
    lo  = 0;
    hi  = eff_count() - 1;
    hit = 1'b0;
    while (lo <= hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (!shadow_set[mid]) add_write(POS_W'(mid), fill_value(mid));
      if ($signed(shadow_keys[mid]) == k) hit = 1'b1;
      else if ($signed(shadow_keys[mid]) < k) lo = mid + 1;
      else hi = mid - 1;
    end
    q.op  = OP_SEARCH;
    q.pos = POS_W'($urandom);
    q.key = k;
    query_q.push_back(q);
    queued_items++;
  endtask

  // wait until every queued transaction is accepted and every answer is back
  task automatic settle();
    do @(negedge clk_i);
    while (query_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_count(int unsigned n);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[COUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    count_reg = n[COUNT_W-1:0];
  endtask

  // ascending keys over positions 0..n-1, with occasional duplicates
  task automatic refill_sorted(int n);
    longint stepmax;
    longint v;
    int     i;
    stepmax = 64'd4294967295 / longint'(n + 1);
    v       = -64'sd2147483648 + (longint'($urandom) % stepmax);
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 9) != 0) v = v + (longint'($urandom) % stepmax);
      add_write(POS_W'(i), v[KEY_W-1:0]);
    end
  endtask

  // search key: mostly present keys, then neighbors, extremes and noise
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               n;
    int               p;
    int               tries;
    int               r;
    bit               got;
    n   = eff_count();
    k   = $urandom;
    got = 1'b0;
    r   = $urandom_range(0, 99);
    if (r < 70 && n > 0) begin
      for (tries = 0; tries < 8 && !got; tries++) begin
        p = $urandom_range(0, n - 1);
        if (shadow_set[p]) begin
          k   = shadow_keys[p];
          got = 1'b1;
        end
      end
      if (r >= 55) k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       k = 32'h8000_0000;
        1:       k = 32'h7FFF_FFFF;
        2:       k = 32'h0000_0000;
        default: k = 32'hFFFF_FFFF;
      endcase
    end
    return k;
  endfunction

  task automatic run_random_phase();
    int n;
    int m;
    n = eff_count();
    if (n > 0 && n <= 64 && $urandom_range(0, 3) != 0) refill_sorted(n);
    m = $urandom_range(20, 60);
    repeat (m) begin
      if ($urandom_range(0, 99) < 85) add_search(pick_key());
      else add_write(POS_W'($urandom), $urandom);
    end
  endtask

  // stream driver, with prediction at each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_WRITE;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (in_flight.op == OP_WRITE) key_mem[in_flight.pos] = in_flight.key;
        else answer_q.push_back(binary_lookup(in_flight.key));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (query_q.size() != 0) begin
          in_flight      = query_q.pop_front();
          s_axis_tdata  <= IN_DATA_W'({in_flight.key, in_flight.pos});
          s_axis_tuser  <= in_flight.op;
          s_axis_tvalid <= 1'b1;
          send_gap      <= idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          log_fail($sformatf("unexpected result: found %0d position %0d",
                             m_axis_tuser, m_axis_tdata[POS_W-1:0]));
        end else begin
          due = answer_q.pop_front();
          if (m_axis_tuser !== due.found || m_axis_tdata[POS_W-1:0] !== due.pos) begin
            log_fail($sformatf("mismatch: expected found %0d position %0d, got found %0d position %0d",
                               due.found, due.pos, m_axis_tuser, m_axis_tdata[POS_W-1:0]));
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap      <= idle_len();
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    int phase;
    int n;
    int r;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three keys at the signed extremes and zero, plus the top position
    set_count(3);
    add_write(POS_W'(0), 32'h8000_0000);
    add_write(POS_W'(1), 32'h0000_0000);
    add_write(POS_W'(2), 32'h7FFF_FFFF);
    add_write(POS_W'(TABLE_DEPTH - 1), 32'hA5A5_5A5A);
    add_search(32'h0000_0000);
    add_search(32'h8000_0000);
    add_search(32'h7FFF_FFFF);
    add_search(32'h0000_0001);
    add_search(32'hFFFF_FFFF);
    add_search(32'h7FFF_FFFE);
    // empty table
    set_count(0);
    add_search(32'h0000_0000);
    // duplicate keys return the first probed position
    set_count(4);
    add_write(POS_W'(0), 32'd7);
    add_write(POS_W'(1), 32'd7);
    add_write(POS_W'(2), 32'd7);
    add_write(POS_W'(3), 32'd7);
    add_search(32'd7);
    add_search(32'd8);
    // unsorted table follows the probe path as it is
    set_count(2);
    add_write(POS_W'(0), 32'd9);
    add_write(POS_W'(1), 32'd3);
    add_search(32'd3);

    // random phases over many table sizes
    queued_items = 0;
    phase        = 0;
    while (queued_items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (phase == 0) n = TABLE_DEPTH;
      else if (phase == 1) n = (1 << COUNT_W) - 1;
      else if (r < 8) n = 0;
      else if (r < 20) n = $urandom_range(1, 3);
      else if (r < 65) n = $urandom_range(4, 64);
      else if (r < 80) n = $urandom_range(65, TABLE_DEPTH - 1);
      else if (r < 90) n = TABLE_DEPTH;
      else n = $urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
      steady = ($urandom_range(0, 3) == 0);
      set_count(n);
      run_random_phase();
      phase++;
    end

    settle();
    if (fail_cnt == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/skbs_pkg.sv
design/skbs_ram.sv
design/skbs_ctrl.sv
design/skbs_dp.sv
design/sorted_key_binary_search.sv
design/skbs_checker.sv
dv/tb_sorted_key_binary_search.sv
